[src/tccs_pkg.sv]
// Shared constants, payload types and address helper for the text console engine.
`default_nettype none
package tccs_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS = 25;
	localparam int CELLS = COLUMNS * ROWS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int CNT_W = $clog2(CELLS + 1);
	localparam int COL_W = 7;
	localparam int ROW_W = 5;
	localparam int ENTRY_W = 16;

	localparam logic [1:0] CMD_PUT = 2'd0;
	localparam logic [1:0] CMD_PLACE = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;
	localparam logic [1:0] CMD_READ = 2'd3;

	localparam logic [7:0] NEWLINE_CODE = 8'd10;
	localparam logic [7:0] BLANK_CODE = 8'h20;
	localparam logic [7:0] RESET_ATTR = 8'h07;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] char_code;
		logic [3:0] fore_color;
		logic [3:0] back_color;
		logic [COL_W-1:0] pos_column;
		logic [ROW_W-1:0] pos_row;
	} req_t;

	typedef struct packed {
		logic [COL_W-1:0] cursor_column;
		logic [ROW_W-1:0] cursor_row;
		logic [ENTRY_W-1:0] read_entry;
		logic did_scroll;
	} rsp_t;

	typedef struct packed {
		logic we;
		logic [ADDR_W-1:0] waddr;
		logic [ENTRY_W-1:0] wdata;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col);
		return ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
	endfunction

endpackage
`default_nettype wire

[src/tccs_ram.sv]
// Screen store: one write port and one registered read port.
`default_nettype none
module tccs_ram (
	input  wire logic                          clk,
	input  wire tccs_pkg::mem_req_t            mem,
	output logic [tccs_pkg::ENTRY_W-1:0]       rdata
);
	import tccs_pkg::*;

	logic [ENTRY_W-1:0] mem_q [0:CELLS-1];

	always_ff @(posedge clk) begin
		if (mem.we) begin
			mem_q[mem.waddr] <= mem.wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[mem.raddr];
	end

endmodule
`default_nettype wire

[src/tccs_ctrl.sv]
// Command sequencer: cursor, screen fill, scroll copy and entry read.
`default_nettype none
module tccs_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_ready,
	input  wire tccs_pkg::req_t                req,
	input  wire logic [7:0]                    text_attr,
	input  wire logic                          slot_free,
	output logic                               res_valid,
	output tccs_pkg::rsp_t                     res,
	output tccs_pkg::mem_req_t                 mem,
	input  wire logic [tccs_pkg::ENTRY_W-1:0]  rdata
);
	import tccs_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_FILL   = 6'b000010,
		ST_SCROLL = 6'b000100,
		ST_BLANK  = 6'b001000,
		ST_READ   = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [ENTRY_W-1:0] fill_entry_q;
	logic fill_reply_q;
	logic read_ok_q;
	rsp_t rsp_q;
	logic cp_valid_s1;
	logic [ADDR_W-1:0] cp_addr_s1;

	logic accept;
	logic in_range;
	logic is_nl;
	logic [COL_W:0] col_inc;
	logic wrap;
	logic [ROW_W:0] row_inc;
	logic scroll_need;
	logic [COL_W-1:0] next_col;
	logic [ROW_W-1:0] next_row;

	assign req_ready = (state_q == ST_IDLE);
	assign accept = req_valid && req_ready;
	assign res_valid = (state_q == ST_DONE);
	assign res = rsp_q;

	assign in_range = ({1'b0, req.pos_column} < (COL_W+1)'(COLUMNS))
		&& ({1'b0, req.pos_row} < (ROW_W+1)'(ROWS));
	assign is_nl = (req.char_code == NEWLINE_CODE);
	assign col_inc = {1'b0, col_q} + (COL_W+1)'(1);
	assign wrap = (col_inc >= (COL_W+1)'(COLUMNS));
	assign next_col = (is_nl || wrap) ? '0 : col_inc[COL_W-1:0];
	assign row_inc = {1'b0, row_q} + {{ROW_W{1'b0}}, (is_nl || wrap)};
	assign scroll_need = (row_inc >= (ROW_W+1)'(ROWS));
	assign next_row = scroll_need ? ROW_W'(ROWS - 1) : row_inc[ROW_W-1:0];

	always_comb begin
		mem.we = 1'b0;
		mem.waddr = cnt_q[ADDR_W-1:0];
		mem.wdata = fill_entry_q;
		mem.raddr = cell_addr(req.pos_row, req.pos_column);
		case (state_q)
			ST_IDLE: begin
				if (accept && (req.cmd == CMD_PUT) && !is_nl) begin
					mem.we = 1'b1;
					mem.waddr = cell_addr(row_q, col_q);
					mem.wdata = {text_attr, req.char_code};
				end else if (accept && (req.cmd == CMD_PLACE)) begin
					mem.we = in_range;
					mem.wdata = {req.back_color, req.fore_color, req.char_code};
					mem.waddr = cell_addr(req.pos_row, req.pos_column);
				end
			end
			ST_FILL: begin
				mem.we = 1'b1;
			end
			ST_SCROLL: begin
				mem.raddr = cnt_q[ADDR_W-1:0];
				mem.we = cp_valid_s1;
				mem.waddr = cp_addr_s1;
				mem.wdata = rdata;
			end
			ST_BLANK: begin
				mem.we = 1'b1;
				mem.wdata = {text_attr, BLANK_CODE};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		cp_addr_s1 <= cnt_q[ADDR_W-1:0] - ADDR_W'(COLUMNS);
		if (accept) begin
			case (req.cmd)
				CMD_PUT: rsp_q <= '{next_col, next_row, '0, scroll_need};
				CMD_CLEAR: rsp_q <= '{'0, '0, '0, 1'b0};
				default: rsp_q <= '{col_q, row_q, '0, 1'b0};
			endcase
		end else if (state_q == ST_READ) begin
			rsp_q.read_entry <= read_ok_q ? rdata : '0;
		end
		if (accept) begin
			read_ok_q <= in_range;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			cnt_q <= '0;
			col_q <= '0;
			row_q <= '0;
			fill_entry_q <= {RESET_ATTR, BLANK_CODE};
			fill_reply_q <= 1'b0;
			cp_valid_s1 <= 1'b0;
		end else begin
			cp_valid_s1 <= (state_q == ST_SCROLL) && (cnt_q < CNT_W'(CELLS));
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.cmd)
							CMD_PUT: begin
								col_q <= next_col;
								row_q <= next_row;
								if (scroll_need) begin
									cnt_q <= CNT_W'(COLUMNS);
									state_q <= ST_SCROLL;
								end else begin
									state_q <= ST_DONE;
								end
							end
							CMD_CLEAR: begin
								col_q <= '0;
								row_q <= '0;
								cnt_q <= '0;
								fill_entry_q <= {text_attr, BLANK_CODE};
								fill_reply_q <= 1'b1;
								state_q <= ST_FILL;
							end
							CMD_READ: state_q <= ST_READ;
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_FILL: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(CELLS - 1)) begin
						state_q <= fill_reply_q ? ST_DONE : ST_IDLE;
					end
				end
				ST_SCROLL: begin
					if (cnt_q == CNT_W'(CELLS)) begin
						cnt_q <= CNT_W'(CELLS - COLUMNS);
						state_q <= ST_BLANK;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_BLANK: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(CELLS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_READ: state_q <= ST_DONE;
				ST_DONE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[src/text_console_cursor_scroll.sv]
// Text console engine top level: attribute register, result register and screen store.
//
// A request on req/req_valid/req_ready carries one command: put a character at
// the cursor, place an entry, clear the screen or read an entry. Every request
// gives exactly one result on rsp/rsp_valid/rsp_ready with the cursor after the
// command, the entry read and the scroll flag. The attribute register is written
// through cfg_valid/cfg_ready/cfg_data; cfg_ready is always high.
// A put character without scroll or a place goes from acceptance through the
// done state to the result register; a read passes the read state first, as the
// screen store has a registered read port. The sequencer takes the next request
// in the cycle after its result moves out.
// A scroll copies the store one entry per cycle and then blanks the last row.
// A clear writes one entry per cycle. After reset the screen store is filled
// with grey spaces, one entry per cycle; requests wait during that pass.
// The result register frees the sequencer, so a new request is taken while a
// result still waits; a second finished result waits until rsp_ready drains the
// first one.
`default_nettype none
module text_console_cursor_scroll (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire tccs_pkg::req_t    req,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output tccs_pkg::rsp_t         rsp,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [7:0]        cfg_data
);
	import tccs_pkg::*;

	logic [7:0] attr_q;
	logic rsp_valid_q;
	rsp_t rsp_q;
	logic slot_free;
	logic res_valid;
	rsp_t res;
	mem_req_t mem;
	logic [ENTRY_W-1:0] rdata;

	assign cfg_ready = 1'b1;
	assign slot_free = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= RESET_ATTR;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				attr_q <= cfg_data;
			end
			if (res_valid && slot_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && slot_free) begin
			rsp_q <= res;
		end
	end

	tccs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.text_attr (attr_q),
		.slot_free (slot_free),
		.res_valid (res_valid),
		.res       (res),
		.mem       (mem),
		.rdata     (rdata)
	);

	tccs_ram u_ram (
		.clk   (clk),
		.mem   (mem),
		.rdata (rdata)
	);

endmodule
`default_nettype wire
